>>> src/assert_macros.svh
// assertion macros, included by the engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property that must hold at every clock edge outside reset
`define ILS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked in the same cycle
`define ILS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// implication whose consequent is checked in the next cycle
`define ILS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define ILS_ASSERT(lbl, prop, msg)
`define ILS_ASSERT_IMP(lbl, ante, cons, msg)
`define ILS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> src/ils_pkg.sv
// types, constants and helpers of the indexed list store
package ils_pkg;

  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 11;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [2:0] CMD_READ       = 3'd0;
  localparam logic [2:0] CMD_PUSH_FRONT = 3'd1;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd2;
  localparam logic [2:0] CMD_INSERT_AT  = 3'd3;
  localparam logic [2:0] CMD_REMOVE_AT  = 3'd4;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic signed [31:0] READ_MISS = -32'sd1;

  typedef struct packed {
    logic [2:0]        command;
    logic [POS_W-1:0]  position;
    logic signed [31:0] value;
  } ils_in_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [1:0]         status;
    logic [POS_W-1:0]   entry_count;
  } ils_out_t;

  typedef struct packed {
    logic              valid;
    ils_out_t          data;
  } ils_res_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [31:0]       wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ils_mem_req_t;

  // count shown modulo 2048
  function automatic logic [POS_W-1:0] to_entry_count(input logic [CNT_W-1:0] cnt);
    logic [CMP_W-1:0] wide;
    wide = CMP_W'(cnt);
    return wide[POS_W-1:0];
  endfunction

endpackage

>>> src/ils_ram.sv
// single write, single read synchronous ram with registered read data
module ils_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> src/ils_engine.sv
// command sequencer: decodes commands and moves entries through the ram
`include "assert_macros.svh"

module ils_engine
  import ils_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cmd_valid,
  input  ils_in_t      in_data,
  input  logic [31:0]  mem_rdata,
  output ils_mem_req_t mem_req,
  output ils_res_t     res,
  output logic         busy
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RDW  = 2'd1;
  localparam logic [1:0] S_UP   = 2'd2;
  localparam logic [1:0] S_DOWN = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [ADDR_W-1:0] ptr_r, ptr_nxt;
  logic [ADDR_W-1:0] lim_r, lim_nxt;
  logic              more_r, more_nxt;
  logic              pend_r, pend_nxt;
  logic [ADDR_W-1:0] pend_addr_r, pend_addr_nxt;
  logic [31:0]       word_r, word_nxt;

  logic [CMP_W-1:0]  pos_x, cnt_x, ins_pos;
  logic              full;

  assign pos_x = CMP_W'(in_data.position);
  assign cnt_x = CMP_W'(count_r);
  assign full  = (count_r == CNT_W'(CAPACITY));
  assign busy  = (state_r != S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    lim_nxt       = lim_r;
    more_nxt      = more_r;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    word_nxt      = word_r;
    mem_req       = '0;
    res           = '0;
    ins_pos       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          case (in_data.command)
            CMD_PUSH_FRONT: ins_pos = '0;
            CMD_PUSH_BACK:  ins_pos = cnt_x;
            default:        ins_pos = pos_x;
          endcase

          unique case (in_data.command) inside
            CMD_READ: begin
              if (pos_x >= cnt_x) begin
                res.valid           = 1'b1;
                res.data.read_value = READ_MISS;
                res.data.status     = ST_RANGE;
              end else begin
                mem_req.re    = 1'b1;
                mem_req.raddr = pos_x[ADDR_W-1:0];
                state_nxt     = S_RDW;
              end
            end
            CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT_AT: begin
              if (ins_pos > cnt_x) begin
                res.valid       = 1'b1;
                res.data.status = ST_RANGE;
              end else if (full) begin
                res.valid       = 1'b1;
                res.data.status = ST_FULL;
              end else if (ins_pos == cnt_x) begin
                // append needs no move
                mem_req.we    = 1'b1;
                mem_req.waddr = ins_pos[ADDR_W-1:0];
                mem_req.wdata = in_data.value;
                count_nxt     = count_r + CNT_W'(1);
                res.valid     = 1'b1;
              end else begin
                ptr_nxt   = ADDR_W'(count_r - CNT_W'(1));
                lim_nxt   = ins_pos[ADDR_W-1:0];
                more_nxt  = 1'b1;
                pend_nxt  = 1'b0;
                word_nxt  = in_data.value;
                state_nxt = S_UP;
              end
            end
            CMD_REMOVE_AT: begin
              if (pos_x >= cnt_x) begin
                res.valid       = 1'b1;
                res.data.status = ST_RANGE;
              end else if (pos_x == cnt_x - CMP_W'(1)) begin
                count_nxt = count_r - CNT_W'(1);
                res.valid = 1'b1;
              end else begin
                ptr_nxt   = pos_x[ADDR_W-1:0] + ADDR_W'(1);
                lim_nxt   = ADDR_W'(count_r - CNT_W'(1));
                more_nxt  = 1'b1;
                pend_nxt  = 1'b0;
                state_nxt = S_DOWN;
              end
            end
            default: begin
              res.valid       = 1'b1;
              res.data.status = ST_RANGE;
            end
          endcase
          res.data.entry_count = to_entry_count(count_nxt);
        end
      end
      S_RDW: begin
        res.valid            = 1'b1;
        res.data.read_value  = mem_rdata;
        res.data.entry_count = to_entry_count(count_r);
        state_nxt            = S_IDLE;
      end
      S_UP, S_DOWN: begin
        // write back the word read last cycle, one slot over
        if (pend_r) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = pend_addr_r;
          mem_req.wdata = mem_rdata;
          pend_nxt      = 1'b0;
        end else if (!more_r) begin
          if (state_r == S_UP) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = lim_r;
            mem_req.wdata = word_r;
            count_nxt     = count_r + CNT_W'(1);
          end else begin
            count_nxt     = count_r - CNT_W'(1);
          end
          res.valid            = 1'b1;
          res.data.entry_count = to_entry_count(count_nxt);
          state_nxt            = S_IDLE;
        end
        if (more_r) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = ptr_r;
          pend_nxt      = 1'b1;
          pend_addr_nxt = (state_r == S_UP) ? ptr_r + ADDR_W'(1) : ptr_r - ADDR_W'(1);
          if (ptr_r == lim_r) begin
            more_nxt = 1'b0;
          end else begin
            ptr_nxt = (state_r == S_UP) ? ptr_r - ADDR_W'(1) : ptr_r + ADDR_W'(1);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      more_r  <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      more_r  <= more_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r       <= ptr_nxt;
    lim_r       <= lim_nxt;
    pend_addr_r <= pend_addr_nxt;
    word_r      <= word_nxt;
  end

  `ILS_ASSERT(a_count_bound, count_r <= CNT_W'(CAPACITY), "entry count above capacity")
  `ILS_ASSERT_IMP(a_idle_no_pend, state_r == S_IDLE, !pend_r, "write back pending while idle")
  `ILS_ASSERT_IMP(a_pend_writes, busy && state_r != S_RDW && pend_r, mem_req.we, "pending move not written")
  `ILS_ASSERT_NEXT(a_res_idle, res.valid, state_r == S_IDLE, "engine busy after result")
  `ILS_ASSERT_IMP(a_no_rw_clash, mem_req.we && mem_req.re, mem_req.waddr != mem_req.raddr, "read and write hit one slot")

endmodule

>>> src/indexed_list_store.sv
// indexed list store top level: handshakes, result register, engine and ram
//
// Ordered list of up to CAPACITY signed 32-bit words held in one ram, with one
// command per transaction: read at a position, insert at the front, at the end
// or before a position, or remove at a position. Each command answers with one
// result transaction carrying the word read (-1 on a miss), a status and the
// entry count afterwards. The result is loaded as follows: an append, a remove
// of the last entry and every refused or out-of-range command answer straight
// from acceptance; an in-range read waits for the registered ram read data; an
// insert before position p or a remove at position p first moves every later
// entry one slot through the ram, one entry per cycle with read and write
// overlapped, after a step that primes the first read and before a step that
// drains the last write and one that finishes the command. One command is in
// work at a time. No clearing pass follows reset: only entries below the count
// are ever read.

module indexed_list_store
  import ils_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  ils_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output ils_out_t out_data
);

  ils_mem_req_t mem_req;
  ils_res_t     res;
  logic [31:0]  mem_rdata;
  logic         busy;
  logic         in_accept;

  logic         out_valid_r, out_valid_nxt;
  ils_out_t     out_data_r, out_data_nxt;

  // hold off while a command is in work or the result slot stays occupied
  assign in_stall  = busy || (out_valid_r && out_stall);
  assign in_accept = in_valid && !in_stall;

  ils_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (in_accept),
    .in_data   (in_data),
    .mem_rdata (mem_rdata),
    .mem_req   (mem_req),
    .res       (res),
    .busy      (busy)
  );

  // entry storage, contents undefined until written
  ils_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (32)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  // result register: a new result only arrives when the slot is free or being taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res.valid) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res.data;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> dv/indexed_list_store_test.sv
`timescale 1ns / 100ps
// self-checking testbench of the indexed list store: directed, random and full-list traffic
module indexed_list_store_test;
  import ils_pkg::*;

  // cycles with no transaction on either side before the run is declared hung;
  // the slowest correct gap is a full-length shift plus
  // the long receiver hold-off plus random stall runs
  localparam int WATCHDOG_CYCLES = 20000;
  localparam int HOLD_CYCLES     = 400;
  localparam int RANDOM_ITEMS    = 450;
  localparam int TAIL_CYCLES     = 40;
  // lists are kept short during random traffic so shifts stay cheap
  localparam int SHORT_LIST      = 48;
  localparam logic [2:0] CMD_LAST_CODE = 3'b111;
  localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;

  logic     clk;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  ils_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  ils_out_t out_data;

  // commands waiting for the driver, and results owed by the block in order
  ils_in_t  cmd_queue[$];
  ils_out_t expected_results[$];

  // predicted list contents, front of the list at index 0
  logic signed [31:0] list_words[$];

  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic hold_request  = 1'b0;
  logic hold_on;
  logic in_took       = 1'b0;
  int   mismatch_count = 0;
  int   quiet_cycles   = 0;

  indexed_list_store uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // applies one command to the predicted list and returns the result it owes
  function automatic ils_out_t list_apply(input ils_in_t cmd);
    ils_out_t res;
    int       len;
    int       pos;
    res = '0;
    res.status = ST_DONE;
    len = list_words.size();
    pos = cmd.position;
    case (cmd.command)
      CMD_READ: begin
        if (pos < len) begin
          res.read_value = list_words[pos];
        end else begin
          res.read_value = READ_MISS;
          res.status = ST_RANGE;
        end
      end
      CMD_PUSH_FRONT: begin
        if (len >= CAPACITY) res.status = ST_FULL;
        else list_words.push_front(cmd.value);
      end
      CMD_PUSH_BACK: begin
        if (len >= CAPACITY) res.status = ST_FULL;
        else list_words.push_back(cmd.value);
      end
      CMD_INSERT_AT: begin
        // the position check wins over the full check
        if (pos > len) res.status = ST_RANGE;
        else if (len >= CAPACITY) res.status = ST_FULL;
        else list_words.insert(pos, cmd.value);
      end
      CMD_REMOVE_AT: begin
        if (pos >= len) res.status = ST_RANGE;
        else list_words.delete(pos);
      end
      default: begin
        // unused command codes change nothing
        res.status = ST_RANGE;
      end
    endcase
    res.entry_count = POS_W'(list_words.size());
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic void queue_cmd(input logic [2:0] code, input int pos,
                                    input logic [31:0] word);
    ils_in_t item;
    item.command  = code;
    item.position = POS_W'(pos);
    item.value    = word;
    cmd_queue.push_back(item);
  endfunction

  // holds until the driver has room, so positions follow the current list length
  task automatic wait_for_room();
    while (cmd_queue.size() > 1) @(posedge clk);
  endtask

  // holds until every command went in and every owed result came out
  task automatic wait_settled();
    while (cmd_queue.size() > 0 || in_valid || expected_results.size() > 0) @(posedge clk);
  endtask

  // random commands, mostly aimed at positions from zero up to the list length
  task automatic queue_random(input int n_items);
    int          len;
    int          pick;
    int          pos;
    logic [2:0]  code;
    logic [31:0] word;
    for (int i = 0; i < n_items; i++) begin
      wait_for_room();
      len = list_words.size();
      pick = $urandom_range(0, 99);
      if (pick < 25) code = CMD_READ;
      else if (pick < 37) code = CMD_PUSH_FRONT;
      else if (pick < 49) code = CMD_PUSH_BACK;
      else if (pick < 63) code = CMD_INSERT_AT;
      else if (pick < 95) code = CMD_REMOVE_AT;
      else code = 3'($urandom_range(CMD_REMOVE_AT + 1, CMD_LAST_CODE));
      // a long list is pulled back down before it gets costly to shift
      if (len > SHORT_LIST && code != CMD_READ) code = CMD_REMOVE_AT;
      case ($urandom_range(0, 9))
        0:       pos = $urandom_range(0, (1 << POS_W) - 1);
        1:       pos = len;
        2:       pos = len + 1;
        default: pos = $urandom_range(0, len);
      endcase
      case ($urandom_range(0, 15))
        0:       word = WORD_MAX;
        1:       word = WORD_MIN;
        2:       word = '1;
        3:       word = '0;
        default: word = $urandom;
      endcase
      queue_cmd(code, pos, word);
    end
  endtask

  // driver: a new transaction is offered once the previous one was taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (cmd_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_data  <= cmd_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, or a solid stall while the hold-off runs
  always @(negedge clk) begin
    out_stall <= hold_on || ($urandom_range(0, 99) < recv_idle_pct);
  end

  // long receiver hold-off so the block backs up and stalls its input
  initial begin
    hold_on = 1'b0;
    wait (hold_request);
    @(negedge clk);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_on <= 1'b0;
  end

  // monitor: results are checked against the oldest owed result, then any
  // accepted command is run through the predictor
  always @(posedge clk) begin
    ils_out_t want;
    in_took <= rst_n && in_valid && !in_stall;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result transaction with no command waiting on it");
      end else begin
        want = expected_results.pop_front();
        if (out_data.read_value !== want.read_value)
          report_mismatch($sformatf("read_value got %0d want %0d",
                                    out_data.read_value, want.read_value));
        if (out_data.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d",
                                    out_data.status, want.status));
        if (out_data.entry_count !== want.entry_count)
          report_mismatch($sformatf("entry_count got %0d want %0d",
                                    out_data.entry_count, want.entry_count));
      end
    end
    if (rst_n && in_valid && !in_stall) expected_results.push_back(list_apply(in_data));
  end

  // watchdog: too long without any transaction means the block is hung
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // phase one: sender mostly busy, receiver stalls about half the time
    send_idle_pct = 11;
    recv_idle_pct = 52;

    // empty list corner cases
    queue_cmd(CMD_READ, 0, '0);
    queue_cmd(CMD_REMOVE_AT, 0, '0);
    queue_cmd(CMD_INSERT_AT, 1, 32'h1234_5678);
    queue_cmd(CMD_REMOVE_AT + 1, 0, 32'h0bad_0001);
    queue_cmd(CMD_LAST_CODE - 1, 3, 32'h0bad_0002);
    queue_cmd(CMD_LAST_CODE, (1 << POS_W) - 1, '1);
    // single entry removed again leaves an empty list
    queue_cmd(CMD_PUSH_BACK, 0, WORD_MAX);
    queue_cmd(CMD_REMOVE_AT, 0, '0);
    // insert at the count appends, then build a short list from both ends
    queue_cmd(CMD_INSERT_AT, 0, WORD_MIN);
    queue_cmd(CMD_PUSH_FRONT, 0, '1);
    queue_cmd(CMD_PUSH_BACK, (1 << POS_W) - 1, '0);
    queue_cmd(CMD_INSERT_AT, 1, 32'h5a5a_5a5a);
    queue_cmd(CMD_READ, 0, '0);
    queue_cmd(CMD_READ, 1, '0);
    queue_cmd(CMD_READ, 2, '0);
    queue_cmd(CMD_READ, 3, '0);
    queue_cmd(CMD_READ, 4, '0);
    queue_cmd(CMD_READ, (1 << POS_W) - 1, '1);
    // middle and last removes, plus out-of-range removes and inserts
    queue_cmd(CMD_REMOVE_AT, 1, '0);
    queue_cmd(CMD_REMOVE_AT, 2, '0);
    queue_cmd(CMD_REMOVE_AT, (1 << POS_W) - 1, '0);
    queue_cmd(CMD_INSERT_AT, (1 << POS_W) - 1, WORD_MAX);
    queue_cmd(CMD_READ, 0, '0);
    queue_cmd(CMD_READ, 1, '0);

    queue_random(RANDOM_ITEMS / 2);
    wait_settled();

    // phase two: sender idles more, receiver rarely stalls
    send_idle_pct = 52;
    recv_idle_pct = 11;
    queue_random(RANDOM_ITEMS - RANDOM_ITEMS / 2);
    wait_settled();

    // phase three: no idling; fill the list to capacity while the receiver
    // holds off for a while at the start
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request = 1'b1;
    while (list_words.size() < CAPACITY) begin
      wait_for_room();
      queue_cmd(CMD_PUSH_BACK, 0, $urandom);
    end
    wait_settled();

    // full list: every insert is refused, but the position check comes first
    queue_cmd(CMD_PUSH_FRONT, 0, 32'hdead_0001);
    queue_cmd(CMD_PUSH_BACK, 0, 32'hdead_0002);
    queue_cmd(CMD_INSERT_AT, CAPACITY, 32'hdead_0003);
    queue_cmd(CMD_INSERT_AT, CAPACITY + 1, 32'hdead_0004);
    queue_cmd(CMD_INSERT_AT, 0, 32'hdead_0005);
    queue_cmd(CMD_READ, 0, '0);
    queue_cmd(CMD_READ, CAPACITY - 1, '0);
    queue_cmd(CMD_READ, CAPACITY, '0);
    queue_cmd(CMD_REMOVE_AT, CAPACITY, '0);
    // longest shifts: remove and insert at the front of a full list
    queue_cmd(CMD_REMOVE_AT, 0, '0);
    queue_cmd(CMD_INSERT_AT, 0, WORD_MIN);
    queue_cmd(CMD_READ, 0, '0);
    queue_cmd(CMD_REMOVE_AT, CAPACITY - 1, '0);
    queue_cmd(CMD_PUSH_FRONT, 0, WORD_MAX);
    queue_cmd(CMD_READ, 1, '0);
    queue_cmd(CMD_READ, CAPACITY - 1, '0);
    wait_settled();

    // let any stray result show up before the verdict
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
